>>> rtl/core/ecef_enu_frame_rotate_top_macros.svh
// Assertion macros used by the checker file of the frame rotator.
`ifndef ECEF_ENU_FRAME_ROTATE_TOP_MACROS_SVH
`define ECEF_ENU_FRAME_ROTATE_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent, quiet during reset.
`define EEFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent, quiet during reset.
`define EEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent, also while reset is applied.
`define EEFR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/eefr_pkg.sv
`default_nettype none

package eefr_pkg;

    // Fixed-point formats
    localparam int TRIG_FRAC = 30;              // trig values and pair products
    localparam int TW        = 32;              // trig register width
    localparam int PW        = 2 * TW;          // trig pair product width
    localparam int CW        = 40;              // coordinate width
    localparam int DW        = CW + 1;          // coordinate minus origin
    localparam int DLW       = 21;              // low slice of a difference
    localparam int DHW       = DW - DLW;        // high slice of a difference
    localparam int PLW       = TW + DLW + 1;    // coefficient times low slice
    localparam int PHW       = TW + DHW;        // coefficient times high slice
    localparam int HSW       = PHW + 2;         // sum of three high products
    localparam int SW        = TW + DW + 2;     // full weighted sum
    localparam int YW        = SW - TRIG_FRAC;  // weighted sum in coordinate units
    localparam int RW        = YW + 1;          // after adding the origin back
    localparam int IDXW      = 3;               // configuration index width

    typedef logic signed [TW-1:0] t_trig;
    typedef logic signed [CW-1:0] t_coord;

    localparam t_trig  TRIG_ONE  = t_trig'(longint'(1) << TRIG_FRAC);
    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic CMD_TO_ENU  = 1'b0;
    localparam logic CMD_TO_ECEF = 1'b1;

    typedef enum logic [IDXW-1:0] {
        REG_SIN_LAT,
        REG_COS_LAT,
        REG_SIN_LON,
        REG_COS_LON,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z
    } t_reg_idx;

    typedef struct packed {
        logic   cmd;
        t_coord coord_a;
        t_coord coord_b;
        t_coord coord_c;
    } t_in;

    typedef struct packed {
        t_coord out_a;
        t_coord out_b;
        t_coord out_c;
        logic   saturated;
    } t_out;

    // Forward rotation matrix, coef[row][column], rows east/north/up,
    // columns x/y/z; the inverse reads it transposed. Plus the origin.
    typedef struct packed {
        t_trig  [2:0][2:0] coef;
        t_coord [2:0]      org;
    } t_frame;

endpackage

`default_nettype wire

>>> rtl/core/eefr_frame.sv
`default_nettype none

module eefr_frame
    import eefr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_wdata,
    output t_frame          o_frame
);

    localparam logic signed [PW-1:0] PROD_HALF = PW'(1) << (TRIG_FRAC - 1);
    localparam logic signed [PW-1:0] PROD_ONE  = PW'(1) << (2 * TRIG_FRAC);

    t_trig  r_sa, r_ca, r_so, r_co;
    t_coord [2:0] r_org;

    logic signed [PW-1:0] r_p_saco, r_p_saso, r_p_caco, r_p_caso;

    t_trig [2:0][2:0] r_coef;

    function automatic t_trig clamp_trig(input logic [TW-1:0] raw);
        t_trig v;
        v = $signed(raw);
        if (v > TRIG_ONE) begin
            return TRIG_ONE;
        end else if (v < -TRIG_ONE) begin
            return -TRIG_ONE;
        end
        return v;
    endfunction

    function automatic t_trig round_prod(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + PROD_HALF;
        return t_trig'(s >>> TRIG_FRAC);
    endfunction

    // Clamp trig values on the way in; drop writes beyond the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa  <= '0;
            r_ca  <= TRIG_ONE;
            r_so  <= '0;
            r_co  <= TRIG_ONE;
            r_org <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIN_LAT:  r_sa     <= clamp_trig(i_cfg_wdata[TW-1:0]);
                REG_COS_LAT:  r_ca     <= clamp_trig(i_cfg_wdata[TW-1:0]);
                REG_SIN_LON:  r_so     <= clamp_trig(i_cfg_wdata[TW-1:0]);
                REG_COS_LON:  r_co     <= clamp_trig(i_cfg_wdata[TW-1:0]);
                REG_ORIGIN_X: r_org[0] <= i_cfg_wdata;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_wdata;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_saco <= '0;
            r_p_saso <= '0;
            r_p_caco <= PROD_ONE;
            r_p_caso <= '0;
        end else begin
            r_p_saco <= PW'(r_sa) * PW'(r_co);
            r_p_saso <= PW'(r_sa) * PW'(r_so);
            r_p_caco <= PW'(r_ca) * PW'(r_co);
            r_p_caso <= PW'(r_ca) * PW'(r_so);
        end
    end

    // Round the pair products and lay out the forward matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0][0] <= '0;
            r_coef[0][1] <= TRIG_ONE;
            r_coef[0][2] <= '0;
            r_coef[1][0] <= '0;
            r_coef[1][1] <= '0;
            r_coef[1][2] <= TRIG_ONE;
            r_coef[2][0] <= TRIG_ONE;
            r_coef[2][1] <= '0;
            r_coef[2][2] <= '0;
        end else begin
            r_coef[0][0] <= -r_so;
            r_coef[0][1] <= r_co;
            r_coef[0][2] <= '0;
            r_coef[1][0] <= -round_prod(r_p_saco);
            r_coef[1][1] <= -round_prod(r_p_saso);
            r_coef[1][2] <= r_ca;
            r_coef[2][0] <= round_prod(r_p_caco);
            r_coef[2][1] <= round_prod(r_p_caso);
            r_coef[2][2] <= r_sa;
        end
    end

    assign o_frame.coef = r_coef;
    assign o_frame.org  = r_org;

endmodule

`default_nettype wire

>>> rtl/core/ecef_enu_frame_rotate_top.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
// request   in         i_in_valid / o_in_ready    i_in_data (t_in)
// result    out        o_out_valid / i_out_ready  o_out_data (t_out)
//
// One request per cycle enters while o_in_ready is high; its result passes
// through six register stages (input, difference, partial products, column
// sums, scale, clamp), one bank of 18 multipliers working every cycle.
// A trig write reaches the rotation matrix via the pair product register
// (product entries only), then rounding. Synchronous active-low reset
// empties every stage and loads the frame for zero latitude and longitude.
// A stall at the result holds each full stage; empty stages take requests.

module ecef_enu_frame_rotate_top
    import eefr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in             i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out            o_out_data
);

    localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (TRIG_FRAC - 1);

    t_frame w_frame;

    eefr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_frame     (w_frame)
    );

    // Stage valid bits and the direction of each request in flight.
    logic [6:1] r_v;
    logic [6:1] en;
    logic [5:1] r_cmd;

    // Stage payloads.
    t_coord                 r_c1 [3];
    logic signed [DW-1:0]   r_d2 [3];
    logic signed [PLW-1:0]  r_pl [3][3];
    logic signed [PHW-1:0]  r_ph [3][3];
    logic signed [SW-1:0]   r_ls [3];
    logic signed [HSW-1:0]  r_hs [3];
    logic signed [YW-1:0]   r_y  [3];
    t_out                   r_out;

    logic signed [DW-1:0]   n_d  [3];
    logic signed [PLW-1:0]  n_pl [3][3];
    logic signed [PHW-1:0]  n_ph [3][3];
    logic signed [SW-1:0]   n_ls [3];
    logic signed [HSW-1:0]  n_hs [3];
    logic signed [YW-1:0]   n_y  [3];
    t_out                   n_out;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[6] = !r_v[6] || i_out_ready;
        for (int k = 5; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: capture the request.
    always_ff @(posedge i_clk) begin
        if (en[1] && i_in_valid) begin
            r_cmd[1] <= i_in_data.cmd;
            r_c1[0]  <= i_in_data.coord_a;
            r_c1[1]  <= i_in_data.coord_b;
            r_c1[2]  <= i_in_data.coord_c;
        end
    end

    // Stage 2: subtract the origin when going into ENU, at full 41-bit width.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_cmd[1] == CMD_TO_ENU) begin
                n_d[i] = DW'(r_c1[i]) - DW'($signed(w_frame.org[i]));
            end else begin
                n_d[i] = DW'(r_c1[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2] && r_v[1]) begin
            r_cmd[2] <= r_cmd[1];
            r_d2     <= n_d;
        end
    end

    // Stage 3: split each difference into a signed high slice and an
    // unsigned low slice so every multiplier stays near 32 by 22 bits.
    // The inverse takes the transposed matrix.
    always_comb begin
        logic signed [TW-1:0]  c;
        logic signed [DLW:0]   dl;
        logic signed [DHW-1:0] dh;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (r_cmd[2] == CMD_TO_ENU) begin
                    c = w_frame.coef[j][i];
                end else begin
                    c = w_frame.coef[i][j];
                end
                dl         = $signed({1'b0, r_d2[i][DLW-1:0]});
                dh         = $signed(r_d2[i][DW-1:DLW]);
                n_pl[j][i] = PLW'(c) * PLW'(dl);
                n_ph[j][i] = PHW'(c) * PHW'(dh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3] && r_v[2]) begin
            r_cmd[3] <= r_cmd[2];
            r_pl     <= n_pl;
            r_ph     <= n_ph;
        end
    end

    // Stage 4: sum the three products of each output; fold the rounding
    // half into the low sum.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_ls[j] = SW'(r_pl[j][0]) + SW'(r_pl[j][1]) + SW'(r_pl[j][2]) + RND_HALF;
            n_hs[j] = HSW'(r_ph[j][0]) + HSW'(r_ph[j][1]) + HSW'(r_ph[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4] && r_v[3]) begin
            r_cmd[4] <= r_cmd[3];
            r_ls     <= n_ls;
            r_hs     <= n_hs;
        end
    end

    // Stage 5: join the slices and floor-shift back to coordinate units.
    always_comb begin
        logic signed [SW-1:0] t;
        for (int j = 0; j < 3; j++) begin
            t      = (SW'(r_hs[j]) <<< DLW) + r_ls[j];
            n_y[j] = YW'(t >>> TRIG_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5] && r_v[4]) begin
            r_cmd[5] <= r_cmd[4];
            r_y      <= n_y;
        end
    end

    // Stage 6: add the origin back for the inverse, then clamp to 40 bits
    // and flag any clamped component.
    always_comb begin
        logic signed [RW-1:0] r;
        t_coord               v [3];
        logic [2:0]           ovf;
        for (int j = 0; j < 3; j++) begin
            if (r_cmd[5] == CMD_TO_ECEF) begin
                r = RW'(r_y[j]) + RW'($signed(w_frame.org[j]));
            end else begin
                r = RW'(r_y[j]);
            end
            ovf[j] = (r[RW-1:CW-1] != {(RW-CW+1){r[RW-1]}});
            if (ovf[j]) begin
                v[j] = r[RW-1] ? COORD_MIN : COORD_MAX;
            end else begin
                v[j] = r[CW-1:0];
            end
        end
        n_out.out_a     = v[0];
        n_out.out_b     = v[1];
        n_out.out_c     = v[2];
        n_out.saturated = |ovf;
    end

    always_ff @(posedge i_clk) begin
        if (en[6] && r_v[5]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v[6];
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/eefr_checker.sv
`default_nettype none
`include "ecef_enu_frame_rotate_top_macros.svh"

module eefr_checker
    import eefr_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input t_out            o_out_data
);

    // Reset empties the pipeline.
    `EEFR_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, (!o_out_valid), "result after reset")

    // Hold a stalled result.
    `EEFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready), (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // With no result waiting, every stage can move, so requests are taken.
    `EEFR_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, (!o_out_valid), (o_in_ready), "request blocked with empty output")

    // The flag only rises when some component sits at a range bound.
    `EEFR_ASSERT_NOW(a_sat_at_bound, i_clk, i_rst_n, (o_out_valid && o_out_data.saturated), ((o_out_data.out_a == COORD_MAX) || (o_out_data.out_a == COORD_MIN) || (o_out_data.out_b == COORD_MAX) || (o_out_data.out_b == COORD_MIN) || (o_out_data.out_c == COORD_MAX) || (o_out_data.out_c == COORD_MIN)), "saturated without a clamped component")

endmodule

bind ecef_enu_frame_rotate_top eefr_checker u_eefr_checker (.*);

`default_nettype wire
